// ===== rtl/cds_pkg.sv =====
// ============================================================================
// cds_pkg: shared types and constants of the C-SCAN request scheduler
// Field widths, configuration register indexes, request classes and the
// control structures passed between the scheduler and its scan unit.
// ============================================================================
package cds_pkg;

  localparam int TRACK_W          = 16;
  localparam int DTRACK_W         = 17;
  localparam int SEEK_W           = 18;
  localparam int CFG_DATA_W       = 17;
  localparam int CFG_IDX_W        = 1;
  localparam int MAX_REQUESTS_DEF = 16;

  localparam logic [TRACK_W-1:0]  START_HEAD_RST  = 16'd0;
  localparam logic [DTRACK_W-1:0] DISK_TRACKS_RST = 17'd200;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_HEAD  = 1'b0,
    CFG_DISK_TRACKS = 1'b1
  } cfg_idx_t;

  // Service class of a request relative to the head; sorts ahead of the value.
  typedef enum logic [1:0] {
    CLS_EQ    = 2'd0,
    CLS_ABOVE = 2'd1,
    CLS_BELOW = 2'd2
  } cls_t;

  typedef struct packed {
    logic start;
    logic clear;
  } scan_ctl_t;

  typedef struct packed {
    logic               done;
    cls_t               cls;
    logic [TRACK_W-1:0] track;
  } scan_rsp_t;

  // Top track from the track count, with the count held to 2..65536.
  function automatic logic [TRACK_W-1:0] top_of(input logic [DTRACK_W-1:0] tracks);
    logic [DTRACK_W-1:0] dec;
    dec = tracks - 1'b1;
    if (tracks < 17'd2) begin
      top_of = 16'd1;
    end else if (tracks[DTRACK_W-1] && (tracks[TRACK_W-1:0] != '0)) begin
      top_of = '1;
    end else begin
      top_of = dec[TRACK_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/cds_req_mem.sv =====
// ============================================================================
// cds_req_mem: request store
// Single write port, single read port, read data registered.
// ============================================================================
module cds_req_mem #(
  parameter int DEPTH  = cds_pkg::MAX_REQUESTS_DEF,
  parameter int ADDR_W = 4
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [cds_pkg::TRACK_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [cds_pkg::TRACK_W-1:0] rd_data
);

  logic [cds_pkg::TRACK_W-1:0] mem [DEPTH];
  logic [cds_pkg::TRACK_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/cds_min_scan.sv =====
// ============================================================================
// cds_min_scan: next-in-order search over the request store
// Each pass reads every stored request and keeps the smallest service key
// that lies above the key returned by the previous pass.
// ============================================================================
module cds_min_scan #(
  parameter int IDX_W        = 4,
  parameter int CNT_W        = 5
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cds_pkg::scan_ctl_t          ctl,
  input  logic [CNT_W-1:0]            cnt,
  input  logic [cds_pkg::TRACK_W-1:0] head,
  output logic [IDX_W-1:0]            rd_addr,
  input  logic [cds_pkg::TRACK_W-1:0] rd_data,
  output cds_pkg::scan_rsp_t          rsp
);

  // Key: class, track, store index. The index makes every key unique so that
  // duplicate tracks are each returned once.
  localparam int KEY_W = 2 + cds_pkg::TRACK_W + IDX_W;

  logic             busy_r;
  logic [CNT_W-1:0] addr_r;
  logic             dv_r;
  logic             dlast_r;
  logic [IDX_W-1:0] didx_r;
  logic             best_vld_r;
  logic [KEY_W-1:0] best_key_r;
  logic             last_vld_r;
  logic [KEY_W-1:0] last_key_r;
  logic             done_r;

  logic [CNT_W-1:0] addr_inc;
  cds_pkg::cls_t    cand_cls;
  logic [KEY_W-1:0] cand_key;
  logic             take;

  assign addr_inc = addr_r + 1'b1;
  assign rd_addr  = addr_r[IDX_W-1:0];

  always_comb begin
    priority if (rd_data == head) begin
      cand_cls = cds_pkg::CLS_EQ;
    end else if (rd_data > head) begin
      cand_cls = cds_pkg::CLS_ABOVE;
    end else begin
      cand_cls = cds_pkg::CLS_BELOW;
    end
  end

  assign cand_key = {cand_cls, rd_data, didx_r};
  assign take     = dv_r && (!last_vld_r || (cand_key > last_key_r))
                         && (!best_vld_r || (cand_key < best_key_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      dv_r       <= 1'b0;
      dlast_r    <= 1'b0;
      done_r     <= 1'b0;
      best_vld_r <= 1'b0;
      last_vld_r <= 1'b0;
    end else begin
      dv_r    <= busy_r;
      dlast_r <= busy_r && (addr_inc == cnt);
      didx_r  <= addr_r[IDX_W-1:0];
      done_r  <= dv_r && dlast_r;

      if (ctl.start) begin
        busy_r <= 1'b1;
        addr_r <= '0;
      end else if (busy_r) begin
        addr_r <= addr_inc;
        if (addr_inc == cnt) begin
          busy_r <= 1'b0;
        end
      end

      if (ctl.start) begin
        best_vld_r <= 1'b0;
      end else if (take) begin
        best_vld_r <= 1'b1;
        best_key_r <= cand_key;
      end

      if (ctl.clear) begin
        last_vld_r <= 1'b0;
      end else if (done_r) begin
        last_vld_r <= 1'b1;
        last_key_r <= best_key_r;
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.cls   = cds_pkg::cls_t'(best_key_r[KEY_W-1 -: 2]);
  assign rsp.track = best_key_r[IDX_W +: cds_pkg::TRACK_W];

endmodule

// ===== rtl/cscan_disk_request_scheduler.sv =====
// ============================================================================
// cscan_disk_request_scheduler: C-SCAN disk request scheduler
// Collects a batch of track requests and emits their C-SCAN service order
// with the running seek distance.
// ============================================================================
// Requests are loaded one per clock into a request store of MAX_REQUESTS
// entries; tracks beyond the top track are saturated to it, and requests past
// a full store are dropped. The request marked in_batch_end closes the batch
// and starts the schedule: requests equal to the head first, then those above
// the head ascending, the top track, track 0 after the full return jump, and
// then those below the head ascending. Every result transaction carries the
// running seek total, and out_order_end marks the last one. No request is
// taken while a schedule is being emitted. Each request result costs one pass
// over the store through its single read port: a launch, a read of every
// stored request, the registered read data and compare, and the emit. The
// top and zero results need no pass of their own.
// ============================================================================
module cscan_disk_request_scheduler #(
  parameter int MAX_REQUESTS = cds_pkg::MAX_REQUESTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cds_pkg::TRACK_W-1:0]    in_request_track,
  input  logic                           in_batch_end,
  // Schedule channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cds_pkg::TRACK_W-1:0]    out_service_track,
  output logic [cds_pkg::SEEK_W-1:0]     out_seek_total,
  output logic                           out_order_end,
  // Configuration write port.
  input  logic                           cfg_wr_en,
  input  logic [cds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cds_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REQUESTS);

  // LOAD takes requests. NEXT launches a search pass or goes to the wrap.
  // SCAN waits for the pass. TOP and ZERO emit the two endpoints, and EMIT
  // emits the request found by the last pass.
  typedef enum logic [2:0] {
    S_LOAD,
    S_NEXT,
    S_SCAN,
    S_TOP,
    S_ZERO,
    S_EMIT
  } state_t;

  state_t                        state_r;
  logic [cds_pkg::TRACK_W-1:0]   start_head_r;
  logic [cds_pkg::DTRACK_W-1:0]  disk_tracks_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [CNT_W-1:0]              k_r;
  logic                          wrapped_r;
  logic [cds_pkg::TRACK_W-1:0]   pos_r;
  logic [cds_pkg::SEEK_W-1:0]    seek_r;
  logic [cds_pkg::TRACK_W-1:0]   cand_r;
  logic                          out_valid_r;
  logic [cds_pkg::TRACK_W-1:0]   out_track_r;
  logic [cds_pkg::SEEK_W-1:0]    out_seek_r;
  logic                          out_end_r;

  logic [cds_pkg::TRACK_W-1:0]   top_trk;
  logic [cds_pkg::TRACK_W-1:0]   head_sat;
  logic [cds_pkg::TRACK_W-1:0]   req_sat;
  logic                          in_acc;
  logic                          out_free;
  logic                          out_load;
  logic [CNT_W-1:0]              k_inc;
  logic                          mem_we;
  logic [IDX_W-1:0]              rd_addr;
  logic [cds_pkg::TRACK_W-1:0]   rd_data;
  cds_pkg::scan_ctl_t            scan_ctl;
  cds_pkg::scan_rsp_t            scan_rsp;
  logic [cds_pkg::TRACK_W-1:0]   emit_track;
  logic [cds_pkg::TRACK_W-1:0]   emit_dist;
  logic [cds_pkg::SEEK_W-1:0]    emit_seek;

  // Geometry follows the configuration; the user must keep both registers stable while busy (not enforced).
  assign top_trk  = cds_pkg::top_of(disk_tracks_r);
  assign head_sat = (start_head_r > top_trk) ? top_trk : start_head_r;
  assign req_sat  = (in_request_track > top_trk) ? top_trk : in_request_track;

  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign k_inc    = k_r + 1'b1;

  // The emitting states load the output register whenever it is free.
  assign out_load = out_free && ((state_r == S_TOP) || (state_r == S_ZERO)
                                 || (state_r == S_EMIT));

  // Full store: the request is dropped, but its batch end still counts.
  assign mem_we = in_acc && (cnt_r < CNT_MAX);

  assign scan_ctl.start = (state_r == S_NEXT) && (k_r < cnt_r);
  assign scan_ctl.clear = in_acc && in_batch_end;

  cds_req_mem #(
    .DEPTH  (MAX_REQUESTS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (req_sat),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cds_min_scan #(
    .IDX_W        (IDX_W),
    .CNT_W        (CNT_W)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (scan_ctl),
    .cnt     (cnt_r),
    .head    (head_sat),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rsp     (scan_rsp)
  );

  // Track and running seek of the result emitted in the current state. The
  // zero result adds the full return jump; the head already sits at the top.
  always_comb begin
    unique case (state_r)
      S_TOP:   emit_track = top_trk;
      S_ZERO:  emit_track = '0;
      default: emit_track = cand_r;
    endcase
    emit_dist = (emit_track >= pos_r) ? (emit_track - pos_r) : (pos_r - emit_track);
    if (state_r == S_ZERO) begin
      emit_seek = seek_r + cds_pkg::SEEK_W'(top_trk);
    end else begin
      emit_seek = seek_r + cds_pkg::SEEK_W'(emit_dist);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_LOAD;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      start_head_r  <= cds_pkg::START_HEAD_RST;
      disk_tracks_r <= cds_pkg::DISK_TRACKS_RST;
    end else begin
      if (cfg_wr_en) begin
        unique case (cds_pkg::cfg_idx_t'(cfg_index))
          cds_pkg::CFG_START_HEAD:  start_head_r  <= cfg_wdata[cds_pkg::TRACK_W-1:0];
          cds_pkg::CFG_DISK_TRACKS: disk_tracks_r <= cfg_wdata;
        endcase
      end

      // A taken result frees the output register unless a new one refills it.
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (mem_we) begin
              cnt_r <= cnt_r + 1'b1;
            end
            if (in_batch_end) begin
              state_r   <= S_NEXT;
              k_r       <= '0;
              wrapped_r <= 1'b0;
              pos_r     <= head_sat;
              seek_r    <= '0;
            end
          end
        end
        S_NEXT: begin
          if (k_r < cnt_r) begin
            state_r <= S_SCAN;
          end else begin
            state_r <= S_TOP;
          end
        end
        S_SCAN: begin
          if (scan_rsp.done) begin
            cand_r <= scan_rsp.track;
            // The first request below the head waits until the wrap is out.
            if ((scan_rsp.cls == cds_pkg::CLS_BELOW) && !wrapped_r) begin
              state_r <= S_TOP;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_TOP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_track_r <= emit_track;
            out_seek_r  <= emit_seek;
            out_end_r   <= 1'b0;
            pos_r       <= top_trk;
            seek_r      <= emit_seek;
            state_r     <= S_ZERO;
          end
        end
        S_ZERO: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_track_r <= emit_track;
            out_seek_r  <= emit_seek;
            out_end_r   <= (k_r == cnt_r);
            pos_r       <= '0;
            seek_r      <= emit_seek;
            wrapped_r   <= 1'b1;
            if (k_r == cnt_r) begin
              state_r <= S_LOAD;
              cnt_r   <= '0;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_track_r <= emit_track;
            out_seek_r  <= emit_seek;
            out_end_r   <= wrapped_r && (k_inc == cnt_r);
            pos_r       <= cand_r;
            seek_r      <= emit_seek;
            k_r         <= k_inc;
            if (wrapped_r && (k_inc == cnt_r)) begin
              state_r <= S_LOAD;
              cnt_r   <= '0;
            end else begin
              state_r <= S_NEXT;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_service_track = out_track_r;
  assign out_seek_total    = out_seek_r;
  assign out_order_end     = out_end_r;

endmodule

// ===== rtl/cds_checker.sv =====
// ============================================================================
// cds_checker: port-level checks of the C-SCAN request scheduler
// Watches both channels of the top level and is bound to it.
// ============================================================================
module cds_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_batch_end,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [cds_pkg::TRACK_W-1:0] out_service_track,
  input logic [cds_pkg::SEEK_W-1:0]  out_seek_total,
  input logic                        out_order_end
);

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_service_track)
      && $stable(out_seek_total) && $stable(out_order_end))
    else $error("stalled result transaction changed");

  // A request that does not close the batch leaves the request side open.
  a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_batch_end |=> !in_stall)
    else $error("request side closed in the middle of a batch");

  // The closing request starts the schedule and stops further loading.
  a_batch_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_batch_end |=> in_stall)
    else $error("request side still open after the batch end");

  // While a schedule is unfinished no new request is taken.
  a_no_load_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_order_end |-> in_stall)
    else $error("request taken while a schedule is pending");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cscan_disk_request_scheduler cds_checker u_cds_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_batch_end      (in_batch_end),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_service_track (out_service_track),
  .out_seek_total    (out_seek_total),
  .out_order_end     (out_order_end)
);
